// ----- rtl/rmq_pkg.sv -----
// Package: widths and path codes for the matrix to quaternion block.
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int DATA_W        = 16;
    localparam int THR_W         = 8;

    typedef enum logic [1:0] {
        PATH_TRACE = 2'd0,
        PATH_X     = 2'd1,
        PATH_Y     = 2'd2,
        PATH_Z     = 2'd3
    } path_t;

endpackage

// ----- rtl/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt #(
    parameter int IN_W = 34,
    parameter int OUT_W = 17,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [IN_W-1:0]  radicand,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [OUT_W-1:0] root,
    output logic [TAG_W-1:0] out_tag
);

    localparam int RW = 2 * OUT_W;

    logic [OUT_W:1]    vld_reg;
    logic [RW-1:0]     rem_reg  [1:OUT_W];
    logic [RW-1:0]     rad_reg  [1:OUT_W];
    logic [OUT_W-1:0]  res_reg  [1:OUT_W];
    logic [TAG_W-1:0]  tag_reg  [1:OUT_W];

    // restoring square root: stage k settles result bit OUT_W-1-k
    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        logic             vld_in;
        logic [RW-1:0]    rem_in;
        logic [RW-1:0]    rad_in;
        logic [OUT_W-1:0] res_in;
        logic [TAG_W-1:0] tag_in;
        logic [RW+1:0]    trial;
        logic [RW+1:0]    cur;
        logic [RW+1:0]    rem_next;
        logic [OUT_W-1:0] res_next;

        // first stage takes the ports, later ones the previous stage
        if (k == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign rad_in = RW'(radicand);
            assign res_in = '0;
            assign tag_in = in_tag;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[k];
            assign rem_in = rem_reg[k];
            assign rad_in = rad_reg[k];
            assign res_in = res_reg[k];
            assign tag_in = tag_reg[k];
        end

        always_comb
        begin
            cur   = {rem_in, rad_in[RW-1 -: 2]};
            trial = {(RW-OUT_W)'(0), res_in, 2'b01};
            if (cur >= trial)
            begin
                rem_next = cur - trial;
                res_next = {res_in[OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = cur;
                res_next = {res_in[OUT_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_in;
        end
        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next[RW-1:0];
            res_reg[k+1] <= res_next;
            rad_reg[k+1] <= {rad_in[RW-3:0], 2'b00};
            tag_reg[k+1] <= tag_in;
        end
    end

    assign out_valid = vld_reg[OUT_W];
    assign root      = res_reg[OUT_W];
    assign out_tag   = tag_reg[OUT_W];

endmodule

// ----- rtl/rmq_div.sv -----
// Pipelined restoring divider with round half away from zero and saturation.
module rmq_div #(
    parameter int N_W = 32,
    parameter int D_W = 18,
    parameter int FB  = 14
) (
    input  logic                  clk,
    input  logic signed [N_W-1:0] num,
    input  logic [D_W-1:0]        den,
    output logic signed [15:0]    quo
);

    // magnitude shifted by FB plus half divisor; quotient bits Q_W
    localparam int M_W = N_W + FB + 1;
    localparam int Q_W = M_W;

    logic [M_W-1:0]  mag_reg [Q_W+1];
    logic [D_W-1:0]  den_reg [Q_W+1];
    logic [D_W:0]    rem_reg [Q_W+1];
    logic            neg_reg [Q_W+1];
    logic            zero_reg[Q_W+1];

    logic [N_W-1:0]  abs_n;
    logic [M_W-1:0]  dividend;
    always_comb
    begin
        abs_n    = num[N_W-1] ? (~num + 1'b1) : num;
        dividend = (M_W'(abs_n) << FB) + M_W'(den >> 1);
    end

    always_ff @(posedge clk)
    begin
        mag_reg[0]  <= dividend;
        den_reg[0]  <= den;
        rem_reg[0]  <= '0;
        neg_reg[0]  <= num[N_W-1];
        zero_reg[0] <= (den == '0);
    end

    // one quotient bit per stage; quotient bits shift into mag_reg
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [D_W+1:0] cur;
        logic [D_W:0]   rem_next;
        logic           qb;
        always_comb
        begin
            cur = {rem_reg[k], mag_reg[k][M_W-1]};
            qb  = (cur >= (D_W+2)'(den_reg[k]));
            rem_next = qb ? (D_W+1)'(cur - (D_W+2)'(den_reg[k])) : cur[D_W:0];
        end
        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            mag_reg[k+1]  <= {mag_reg[k][M_W-2:0], qb};
            den_reg[k+1]  <= den_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            zero_reg[k+1] <= zero_reg[k];
        end
    end

    // sign and 16-bit saturation; a zero divisor gives a zero quotient
    logic [M_W-1:0] q;
    always_comb
    begin
        q = mag_reg[Q_W];
        if (zero_reg[Q_W])
            quo = '0;
        else if (neg_reg[Q_W])
            quo = (q > M_W'(32768)) ? 16'sh8000 : 16'(~q + 1'b1);
        else
            quo = (q > M_W'(32767)) ? 16'sh7fff : 16'(q);
    end

endmodule

// ----- rtl/rotation_matrix_to_quaternion_top.sv -----
// Top level: rotation matrix to quaternion, Shepperd's method, fully pipelined.
//
//  channel  | handshake            | words
//  ---------+----------------------+----------------------------------
//  input    | start, busy          | m00..m22, signed 16 bit
//  result   | done strobe          | qw qx qy qz, path_taken
//  config   | cfg_valid, cfg_ready | cfg_data, trace threshold
//
// One matrix per cycle; the path is 2 registers + R_W root stages
// + (FRAC_BITS+20) divider stages + 1 output register.
// busy is held low: the pipeline never stops, as the receiver cannot stall.
// rst_n clears valid bits and sets the threshold to 1.
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [rmq_pkg::DATA_W-1:0] m00, m01, m02,
    input  logic signed [rmq_pkg::DATA_W-1:0] m10, m11, m12,
    input  logic signed [rmq_pkg::DATA_W-1:0] m20, m21, m22,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rmq_pkg::THR_W-1:0]      cfg_data,
    output logic                           done,
    output logic signed [rmq_pkg::DATA_W-1:0] qw, qx, qy, qz,
    output logic [1:0]                     path_taken
);

    localparam int D_W  = (FRAC_BITS > 16 ? FRAC_BITS : 16) + 3;  // radicand d
    localparam int SQ_W = D_W + FRAC_BITS + (D_W + FRAC_BITS) % 2;
    localparam int R_W  = SQ_W / 2;
    localparam int N_W  = 18;                // off-diagonal sum/difference
    localparam int S_W  = R_W + 1;
    localparam int TAG_W = 2 + 3 * N_W;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic [rmq_pkg::THR_W-1:0] thr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= rmq_pkg::THR_W'(1);
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // stage 1: register the inputs
    logic                       v1_reg;
    logic signed [N_W-1:0]      a_reg [9];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        a_reg[0] <= N_W'(m00); a_reg[1] <= N_W'(m01); a_reg[2] <= N_W'(m02);
        a_reg[3] <= N_W'(m10); a_reg[4] <= N_W'(m11); a_reg[5] <= N_W'(m12);
        a_reg[6] <= N_W'(m20); a_reg[7] <= N_W'(m21); a_reg[8] <= N_W'(m22);
    end

    // stage 2: path choice, radicand and numerators
    localparam logic signed [D_W:0] ONE = (D_W+1)'(1) << FRAC_BITS;
    logic signed [D_W:0]   tr, dsel;
    logic signed [N_W-1:0] n0, n1, n2;
    rmq_pkg::path_t        path;
    always_comb
    begin
        tr = ONE + (D_W+1)'(a_reg[0]) + (D_W+1)'(a_reg[4]) + (D_W+1)'(a_reg[8]);
        if (tr > $signed({1'b0, (D_W)'(thr_reg)}))
        begin
            path = rmq_pkg::PATH_TRACE; dsel = tr;
            n0 = a_reg[7] - a_reg[5]; n1 = a_reg[2] - a_reg[6]; n2 = a_reg[3] - a_reg[1];
        end
        else if (a_reg[0] > a_reg[4] && a_reg[0] > a_reg[8])
        begin
            path = rmq_pkg::PATH_X;
            dsel = ONE + (D_W+1)'(a_reg[0]) - (D_W+1)'(a_reg[4]) - (D_W+1)'(a_reg[8]);
            n0 = a_reg[7] - a_reg[5]; n1 = a_reg[1] + a_reg[3]; n2 = a_reg[2] + a_reg[6];
        end
        else if (a_reg[4] > a_reg[8])
        begin
            path = rmq_pkg::PATH_Y;
            dsel = ONE + (D_W+1)'(a_reg[4]) - (D_W+1)'(a_reg[0]) - (D_W+1)'(a_reg[8]);
            n0 = a_reg[2] - a_reg[6]; n1 = a_reg[1] + a_reg[3]; n2 = a_reg[5] + a_reg[7];
        end
        else
        begin
            path = rmq_pkg::PATH_Z;
            dsel = ONE + (D_W+1)'(a_reg[8]) - (D_W+1)'(a_reg[0]) - (D_W+1)'(a_reg[4]);
            n0 = a_reg[3] - a_reg[1]; n1 = a_reg[2] + a_reg[6]; n2 = a_reg[5] + a_reg[7];
        end
    end

    logic                  v2_reg;
    logic [SQ_W-1:0]       rad_reg;
    logic [TAG_W-1:0]      t2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        rad_reg <= dsel[D_W] ? '0 : (SQ_W'(dsel[D_W-1:0]) << FRAC_BITS);
        t2_reg  <= {path, n0, n1, n2};
    end

    // square root pipeline
    logic             v3;
    logic [R_W-1:0]   root;
    logic [TAG_W-1:0] t3;
    rmq_sqrt #(.IN_W(SQ_W), .OUT_W(R_W), .TAG_W(TAG_W)) u_sqrt (
        .clk, .rst_n, .in_valid(v2_reg), .radicand(rad_reg), .in_tag(t2_reg),
        .out_valid(v3), .root(root), .out_tag(t3)
    );

    // three dividers in parallel
    localparam int DIV_LAT = N_W + FRAC_BITS + 2;
    logic [S_W-1:0]              s;
    logic signed [15:0]          qa, qb, qc;
    assign s = {root, 1'b0};
    rmq_div #(.N_W(N_W), .D_W(S_W), .FB(FRAC_BITS)) u_div0 (
        .clk, .num(t3[3*N_W-1 -: N_W]), .den(s), .quo(qa));
    rmq_div #(.N_W(N_W), .D_W(S_W), .FB(FRAC_BITS)) u_div1 (
        .clk, .num(t3[2*N_W-1 -: N_W]), .den(s), .quo(qb));
    rmq_div #(.N_W(N_W), .D_W(S_W), .FB(FRAC_BITS)) u_div2 (
        .clk, .num(t3[N_W-1:0]), .den(s), .quo(qc));

    // delay valid, path and own component alongside the dividers
    logic [DIV_LAT-1:0] vd_reg;
    logic [1:0]         pd_reg [DIV_LAT];
    logic [15:0]        od_reg [DIV_LAT];
    logic [R_W:0]       rp1;
    logic [15:0]        own;
    always_comb
    begin
        rp1 = (R_W+1)'(root) + 1'b1;
        own = ((rp1 >> 1) > (R_W+1)'(32767)) ? 16'h7fff : 16'(rp1 >> 1);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else
            vd_reg <= {vd_reg[DIV_LAT-2:0], v3};
    end
    always_ff @(posedge clk)
    begin
        pd_reg[0] <= t3[TAG_W-1 -: 2];
        od_reg[0] <= own;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            pd_reg[i] <= pd_reg[i-1];
            od_reg[i] <= od_reg[i-1];
        end
    end

    // output register: place components by path
    logic [1:0] pf;
    logic [15:0] of;
    assign pf = pd_reg[DIV_LAT-1];
    assign of = od_reg[DIV_LAT-1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= vd_reg[DIV_LAT-1];
    end
    always_ff @(posedge clk)
    begin
        path_taken <= pf;
        case (pf)
            rmq_pkg::PATH_TRACE: begin qw <= of; qx <= qa; qy <= qb; qz <= qc; end
            rmq_pkg::PATH_X:     begin qw <= qa; qx <= of; qy <= qb; qz <= qc; end
            rmq_pkg::PATH_Y:     begin qw <= qa; qx <= qb; qy <= of; qz <= qc; end
            default:             begin qw <= qa; qx <= qb; qy <= qc; qz <= of; end
        endcase
    end

endmodule

// ----- rtl/rmq_checker.sv -----
// Port checker for the matrix to quaternion block, bound to the top level.
module rmq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        cfg_ready,
    input logic        done,
    input logic [1:0]  path_taken,
    input logic signed [15:0] qw
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config not ready");
    a_no_done_after_reset: assert property (@(posedge clk) !rst_n |=> !done)
        else $error("result word straight after reset");
    a_trace_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && path_taken == rmq_pkg::PATH_TRACE) |-> !qw[15])
        else $error("negative scalar on trace path");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
    .clk, .rst_n, .busy, .cfg_ready, .done, .path_taken, .qw
);
